// ===== rtl/core/rria_pkg.sv =====
// Shared types and constants for the ranged register ID allocator.
// Holds operation codes, controller state, command struct and class range masks.
// No dependencies.
`default_nettype none

package rria_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned MASK_W  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_MARK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_PAIR    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input beat and read its class word
    logic exec;  // update the map and load the result register
  } ctrl_cmd_t;

  // Legal IDs of each class, one bit per ID
  function automatic logic [MASK_W-1:0] class_mask(input logic [CLASS_W-1:0] cls);
    logic [MASK_W-1:0] m;
    unique case (cls)
      3'd0:    m = 64'h3FFF_FC00_FC00_0380;
      3'd1:    m = 64'hFFFF_FFFF_FFFF_FFFF;
      3'd2:    m = 64'h0000_0000_0000_007F;
      3'd3:    m = 64'h0000_0000_0000_FC00;
      3'd4:    m = 64'h0000_0000_0000_00FF;
      3'd5:    m = 64'h0000_0000_0000_FF00;
      3'd6:    m = 64'h0000_0000_0000_007F;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Even IDs whose successor lies in the same range
  function automatic logic [MASK_W-1:0] pair_mask(input logic [CLASS_W-1:0] cls);
    logic [MASK_W-1:0] m;
    unique case (cls)
      3'd0:    m = 64'h1555_5400_5400_0100;
      3'd1:    m = 64'h5555_5555_5555_5555;
      3'd2:    m = 64'h0000_0000_0000_0015;
      3'd3:    m = 64'h0000_0000_0000_5400;
      3'd4:    m = 64'h0000_0000_0000_0055;
      3'd5:    m = 64'h0000_0000_0000_5500;
      3'd6:    m = 64'h0000_0000_0000_0015;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ranged_register_id_allocator.sv =====
// Top level of the ranged register ID allocator.
// Instantiates rria_ctrl and rria_dp; uses rria_pkg.
//
// One used map per register class with fixed legal ID ranges. Operations: mark
// used, allocate the lowest free ID, allocate the first aligned free pair inside
// one range, release, and clear all. A failed allocation returns status 1 with
// zero IDs and leaves the maps alone. Every accepted beat gives exactly one
// result beat. An item is handled in two steps: one captures the request and
// reads its class word, one searches and writes the word back; the single map
// read-modify-write sets that split. A new beat is taken while the previous
// result waits in the output register, and the execute step waits only if that
// register is still held. Maps are cleared at reset.
`default_nettype none

module ranged_register_id_allocator #(
  parameter int unsigned NUM_CLASSES = 7,
  parameter int unsigned ID_SPACE    = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [rria_pkg::OP_W-1:0]    operation_i,
  input  wire logic [rria_pkg::CLASS_W-1:0] reg_class_i,
  input  wire logic [rria_pkg::ID_W-1:0]    reg_id_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              status_o,
  output logic [rria_pkg::ID_W-1:0]         id_low_o,
  output logic [rria_pkg::ID_W-1:0]         id_high_o
);

  rria_pkg::ctrl_cmd_t cmd;

  rria_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rria_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .ID_SPACE    (ID_SPACE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .operation_i (operation_i),
    .reg_class_i (reg_class_i),
    .reg_id_i    (reg_id_i),
    .status_o    (status_o),
    .id_low_o    (id_low_o),
    .id_high_o   (id_high_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rria_ctrl.sv =====
// Controller of the ranged register ID allocator: accept, execute, result hold.
// Depends on rria_pkg for the state enum and command struct.
`default_nettype none

module rria_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rria_pkg::ctrl_cmd_t     cmd_o
);

  rria_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rria_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rria_pkg::ST_EXEC;
      end
      rria_pkg::ST_EXEC: begin
        if (out_free) state_d = rria_pkg::ST_IDLE;
      end
      default: state_d = rria_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      rria_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      rria_pkg::ST_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rria_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a new result only appears out of the execute state
  a_rise_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rria_pkg::ST_EXEC))
    else $error("result valid without execute");

  // a held result blocks execution of the pending beat
  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rria_pkg::ST_EXEC && out_valid_q && out_stall_i)
      |=> (state_q == rria_pkg::ST_EXEC && out_valid_q))
    else $error("pending beat executed over a held result");

  a_no_double_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.exec))
    else $error("load and exec in one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/rria_dp.sv =====
// Datapath of the ranged register ID allocator: class maps, lowest-free search,
// map update and result register. Depends on rria_pkg.
`default_nettype none

module rria_dp #(
  parameter int unsigned NUM_CLASSES = 7,
  parameter int unsigned ID_SPACE    = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rria_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [rria_pkg::OP_W-1:0]      operation_i,
  input  wire logic [rria_pkg::CLASS_W-1:0]   reg_class_i,
  input  wire logic [rria_pkg::ID_W-1:0]      reg_id_i,
  output logic                                status_o,
  output logic [rria_pkg::ID_W-1:0]           id_low_o,
  output logic [rria_pkg::ID_W-1:0]           id_high_o
);

  localparam int unsigned IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned EXT_W = 5;

  logic [ID_SPACE-1:0] used_q [NUM_CLASSES];

  logic [rria_pkg::OP_W-1:0]    op_q;
  logic [rria_pkg::CLASS_W-1:0] cls_q;
  logic [rria_pkg::ID_W-1:0]    id_q;
  logic [IDX_W-1:0]             idx_q;
  logic                         has_map_q;
  logic [ID_SPACE-1:0]          word_q;

  logic [EXT_W-1:0] cls_ext;
  logic [IDX_W-1:0] idx_in;
  logic             has_map_in;

  assign cls_ext    = EXT_W'(reg_class_i);
  assign idx_in     = cls_ext[IDX_W-1:0];
  assign has_map_in = 32'(reg_class_i) < NUM_CLASSES;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      cls_q     <= reg_class_i;
      id_q      <= reg_id_i;
      idx_q     <= idx_in;
      has_map_q <= has_map_in;
      word_q    <= has_map_in ? used_q[idx_in] : '0;
    end
  end

  // search
  logic [rria_pkg::MASK_W-1:0] legal_full, pair_full;
  logic [ID_SPACE-1:0] legal, pairs, free_ids, cand;
  logic [ID_SPACE-1:0] one_hot, id_bit, new_word;
  logic [rria_pkg::ID_W-1:0] hit_idx;
  logic hit, is_pair, is_alloc, id_in_space, write_en;

  assign legal_full  = rria_pkg::class_mask(cls_q);
  assign pair_full   = rria_pkg::pair_mask(cls_q);
  assign legal       = legal_full[ID_SPACE-1:0];
  assign pairs       = pair_full[ID_SPACE-1:0] & (legal >> 1);
  assign free_ids    = ~word_q;
  assign is_pair     = (op_q == rria_pkg::OP_PAIR);
  assign is_alloc    = (op_q == rria_pkg::OP_ALLOC) || is_pair;
  assign cand        = is_pair ? (free_ids & (free_ids >> 1) & pairs)
                               : (free_ids & legal);
  assign id_in_space = 32'(id_q) < ID_SPACE;

  // lowest set candidate
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ID_SPACE - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_idx = rria_pkg::ID_W'(i);
      end
    end
  end

  assign one_hot = {{(ID_SPACE-1){1'b0}}, 1'b1} << hit_idx;
  assign id_bit  = {{(ID_SPACE-1){1'b0}}, 1'b1} << id_q;

  always_comb begin
    new_word = word_q;
    write_en = 1'b0;
    case (op_q)
      rria_pkg::OP_MARK: begin
        new_word = word_q | id_bit;
        write_en = has_map_q && id_in_space;
      end
      rria_pkg::OP_ALLOC: begin
        new_word = word_q | one_hot;
        write_en = has_map_q && hit;
      end
      rria_pkg::OP_PAIR: begin
        new_word = word_q | one_hot | (one_hot << 1);
        write_en = has_map_q && hit;
      end
      rria_pkg::OP_RELEASE: begin
        new_word = word_q & ~id_bit;
        write_en = has_map_q && id_in_space;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) used_q[c] <= '0;
    end else if (cmd_i.exec) begin
      if (op_q == rria_pkg::OP_CLEAR) begin
        for (int c = 0; c < NUM_CLASSES; c++) used_q[c] <= '0;
      end else if (write_en) begin
        used_q[idx_q] <= new_word;
      end
    end
  end

  // result register
  logic                      res_status_q;
  logic [rria_pkg::ID_W-1:0] res_lo_q, res_hi_q;
  logic                      ok;

  assign ok = has_map_q && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_status_q <= 1'b0;
      res_lo_q     <= '0;
      res_hi_q     <= '0;
    end else if (cmd_i.exec) begin
      res_status_q <= is_alloc && !ok;
      res_lo_q     <= (is_alloc && ok) ? hit_idx : '0;
      res_hi_q     <= (is_pair && ok) ? hit_idx + rria_pkg::ID_W'(1) : '0;
    end
  end

  assign status_o  = res_status_q;
  assign id_low_o  = res_lo_q;
  assign id_high_o = res_hi_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_status_q |-> (res_lo_q == '0 && res_hi_q == '0))
    else $error("failed allocation returned an ID");

  a_pair_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_hi_q != '0) |-> (res_hi_q == res_lo_q + rria_pkg::ID_W'(1) && !res_lo_q[0]))
    else $error("pair IDs not an aligned couple");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == rria_pkg::OP_CLEAR) |=> (used_q[0] == '0))
    else $error("clear-all left a used bit");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for ranged_register_id_allocator.
// Drives request beats with random gaps and output stalls, predicts every result beat from
// per-class used maps kept here, and compares field by field. Needs rria_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rria_pkg::*;

  localparam logic [CLASS_W-1:0] CLS_SCALAR = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_VECTOR = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_VADDR  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_SADDR  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_VOFF   = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_SOFF   = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_SCOND  = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd7;
  localparam int unsigned N_MAPS = 7;

  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam int unsigned TARGET_ITEMS = 550;
  localparam int unsigned MAX_PRINTS   = 100;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CLASS_W-1:0] cls;
    logic [ID_W-1:0]    id;
  } id_req_t;

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] id_low;
    logic [ID_W-1:0] id_high;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    in_op = '0;
  logic [CLASS_W-1:0] in_cls = '0;
  logic [ID_W-1:0]    in_id = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic               status_o;
  logic [ID_W-1:0]    id_low_o;
  logic [ID_W-1:0]    id_high_o;

  ranged_register_id_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .operation_i (in_op),
    .reg_class_i (in_cls),
    .reg_id_i    (in_id),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .id_low_o    (id_low_o),
    .id_high_o   (id_high_o)
  );

  id_req_t     pending_reqs[$];
  grant_t      expected_grants[$];
  logic [63:0] class_used [0:N_MAPS-1] = '{default: '0};
  int unsigned fail_count = 0;
  int unsigned live_items = 0;
  logic        beat_taken = 1'b0;
  bit          quiet = 1'b0;
  int          in_gap = 0;
  int          stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Legal ID range k of a class; returns 0 when the class has no such range.
  function automatic bit range_of(input logic [CLASS_W-1:0] cls, input int k,
                                  output int lo, output int hi);
    lo = 0;
    hi = -1;
    case (cls)
      CLS_SCALAR: begin
        case (k)
          0: begin lo = 7;  hi = 9;  end
          1: begin lo = 26; hi = 31; end
          2: begin lo = 42; hi = 61; end
          default: ;
        endcase
      end
      CLS_VECTOR: if (k == 0) begin lo = 0;  hi = 63; end
      CLS_VADDR:  if (k == 0) begin lo = 0;  hi = 6;  end
      CLS_SADDR:  if (k == 0) begin lo = 10; hi = 15; end
      CLS_VOFF:   if (k == 0) begin lo = 0;  hi = 7;  end
      CLS_SOFF:   if (k == 0) begin lo = 8;  hi = 15; end
      CLS_SCOND:  if (k == 0) begin lo = 0;  hi = 6;  end
      default: ;
    endcase
    return hi >= lo;
  endfunction

  // Expected result of one accepted beat; updates the used maps kept here.
  function automatic grant_t predict_grant(input id_req_t r);
    grant_t g;
    int     lo, hi, k, id;
    bit     found, pair;
    g = '0;
    found = 1'b0;
    pair = (r.op == OP_PAIR);
    case (r.op)
      OP_MARK:    if (r.cls < N_MAPS) class_used[r.cls][r.id] = 1'b1;
      OP_RELEASE: if (r.cls < N_MAPS) class_used[r.cls][r.id] = 1'b0;
      OP_CLEAR:   foreach (class_used[c]) class_used[c] = '0;
      OP_ALLOC, OP_PAIR: begin
        for (k = 0; k < 3 && !found; k++) begin
          if (range_of(r.cls, k, lo, hi)) begin
            // pairs start on an even ID and must end inside the range
            id = pair ? lo + (lo & 1) : lo;
            for (; id + (pair ? 1 : 0) <= hi && !found; id += (pair ? 2 : 1)) begin
              if (!class_used[r.cls][id] && (!pair || !class_used[r.cls][id+1])) begin
                found = 1'b1;
                class_used[r.cls][id] = 1'b1;
                g.id_low = id[ID_W-1:0];
                if (pair) begin
                  class_used[r.cls][id+1] = 1'b1;
                  g.id_high = id[ID_W-1:0] + 1'b1;
                end
              end
            end
          end
        end
        if (!found) g.status = 1'b1;
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic flag_error(input string msg);
    if (fail_count < MAX_PRINTS) $display("%0t MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_grant(input grant_t got, input grant_t want);
    if (got.status !== want.status)
      flag_error($sformatf("status got %b want %b", got.status, want.status));
    if (got.id_low !== want.id_low)
      flag_error($sformatf("id_low got %0d want %0d", got.id_low, want.id_low));
    if (got.id_high !== want.id_high)
      flag_error($sformatf("id_high got %0d want %0d", got.id_high, want.id_high));
  endtask

  // Idle length: mostly none or short, a few long, none at all in quiet stretches.
  function automatic int pick_gap(input int start_pct);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r >= start_pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [CLASS_W-1:0] cls,
                           input logic [ID_W-1:0] id);
    pending_reqs.push_back('{op: op, cls: cls, id: id});
    // undefined codes and mark/release on the map-less class leave the block's maps alone
    if (!(op > OP_CLEAR || (cls == CLS_NONE && (op == OP_MARK || op == OP_RELEASE))))
      live_items++;
  endtask

  function automatic logic [ID_W-1:0] id_in_class(input logic [CLASS_W-1:0] cls);
    int lo, hi;
    if ($urandom_range(0, 3) == 0 || cls == CLS_NONE) return ID_W'($urandom_range(0, 63));
    if (!range_of(cls, $urandom_range(0, 2), lo, hi)) void'(range_of(cls, 0, lo, hi));
    return ID_W'($urandom_range(lo, hi));
  endfunction

  // Request driver: new beat on the falling edge once the previous one was taken.
  always @(negedge clk) begin : drive_requests
    id_req_t nxt;
    if (rst_n) begin
      if (!in_valid || beat_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          in_op    <= nxt.op;
          in_cls   <= nxt.cls;
          in_id    <= nxt.id;
          in_valid <= 1'b1;
          if ($urandom_range(0, 59) == 0) quiet = ~quiet;
          in_gap = pick_gap(45);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(25);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Result checker and predictor, both on the rising edge.
  always @(posedge clk) begin : check_results
    grant_t got;
    if (rst_n) begin
      beat_taken <= in_valid && !in_stall_o;
      if (out_valid_o && !out_stall) begin
        got = {status_o, id_low_o, id_high_o};
        if (expected_grants.size() == 0)
          flag_error("result beat with nothing expected");
        else
          compare_grant(got, expected_grants.pop_front());
      end
      if (in_valid && !in_stall_o)
        expected_grants.push_back(predict_grant('{op: in_op, cls: in_cls, id: in_id}));
    end
  end

  initial begin : stimulus
    int pick, n;
    logic [CLASS_W-1:0] cls;

    // directed: first range entries, pair alignment, exhaustion, ignored cases
    queue_req(OP_ALLOC,   CLS_SCALAR, 6'd63);
    queue_req(OP_PAIR,    CLS_SCALAR, 6'd0);
    queue_req(OP_ALLOC,   CLS_SCALAR, 6'd0);
    queue_req(OP_MARK,    CLS_VECTOR, 6'd63);
    queue_req(OP_MARK,    CLS_VECTOR, 6'd0);
    queue_req(OP_ALLOC,   CLS_VECTOR, 6'd0);
    queue_req(OP_PAIR,    CLS_VECTOR, 6'd0);
    queue_req(OP_RELEASE, CLS_VECTOR, 6'd63);
    queue_req(OP_MARK,    CLS_NONE,   6'd63);
    queue_req(OP_ALLOC,   CLS_NONE,   6'd0);
    queue_req(OP_PAIR,    CLS_NONE,   6'd0);
    queue_req(OP_RELEASE, CLS_NONE,   6'd0);
    repeat (4) queue_req(OP_PAIR, CLS_VADDR, 6'd0);
    repeat (2) queue_req(OP_ALLOC, CLS_VADDR, 6'd0);
    queue_req(OP_MARK,      CLS_SCOND, 6'd63);
    queue_req(OP_RELEASE,   CLS_SCOND, 6'd63);
    queue_req(OP_RSVD_FIRST, CLS_SCOND, 6'd42);
    queue_req(OP_RSVD_LAST,  CLS_NONE,  6'd63);
    queue_req(OP_CLEAR,     CLS_SCALAR, 6'd0);
    queue_req(OP_ALLOC,     CLS_SOFF,   6'd0);
    queue_req(OP_PAIR,      CLS_SADDR,  6'd0);

    // random: allocation bursts, exhaustion runs, releases, marks, clears, noise
    while (live_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      cls = CLASS_W'($urandom_range(0, 6));
      if (pick < 40) begin
        n = $urandom_range(1, 10);
        repeat (n) queue_req($urandom_range(0, 1) ? OP_PAIR : OP_ALLOC, cls,
                             ID_W'($urandom()));
      end else if (pick < 60) begin
        n = $urandom_range(1, 8);
        repeat (n) queue_req(OP_RELEASE, cls, id_in_class(cls));
      end else if (pick < 72) begin
        n = $urandom_range(1, 6);
        repeat (n) queue_req(OP_MARK, cls, id_in_class(cls));
      end else if (pick < 85) begin
        n = $urandom_range(8, cls == CLS_VECTOR ? 40 : 20);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0)
            queue_req(OP_RELEASE, cls, id_in_class(cls));
          else
            queue_req($urandom_range(0, 2) == 0 ? OP_PAIR : OP_ALLOC, cls,
                      ID_W'($urandom()));
        end
      end else if (pick < 90) begin
        queue_req(OP_CLEAR, CLASS_W'($urandom()), ID_W'($urandom()));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) queue_req(OP_W'($urandom()), CLASS_W'($urandom()), ID_W'($urandom()));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_grants.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_grants.size()));
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
